// ===== hw/rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Field widths, request and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

	localparam int KEY_W     = 10;
	localparam int REQ_W     = 3;
	localparam int CNT_W     = 5;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [KEY_W-1:0] THR_RESET = 10'd18;
	localparam logic [KEY_W-1:0] RMV_RESET = 10'd30;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REMOVE    = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 3'd0,
		REQ_COUNT  = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_MIN    = 3'd3,
		REQ_LIST   = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_PLACE,
		S_RESP
	} state_t;

	// write port source
	typedef enum logic [1:0] {
		WR_SHIFT,     // read data up one slot
		WR_KEY_ABOVE, // key just above current entry
		WR_KEY_ZERO,  // key at the bottom slot
		WR_COMPACT    // read data at the compaction pointer
	} wr_sel_t;

	typedef enum logic {
		VAL_ZERO,
		VAL_DATA
	} val_sel_t;

	typedef enum logic [1:0] {
		CNT_ZERO,
		CNT_HELD,
		CNT_ACC
	} cnt_sel_t;

	typedef struct packed {
		logic     key_ld;
		logic     acc_clr;
		logic     ptr_first;
		logic     ptr_top;
		logic     ptr_inc;
		logic     ptr_dec;
		logic     mem_wr;
		wr_sel_t  wr_sel;
		logic     n_inc;
		logic     n_from_wp;
		logic     wp_inc;
		logic     acc_inc;
		logic     emit;
		val_sel_t val_sel;
		cnt_sel_t cnt_sel;
		status_t  status;
		logic     last;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_full;
		logic ptr_zero;
		logic ptr_last;
		logic gt_key;
		logic lt_thr;
		logic eq_rmv;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skt_intf.sv =====
// ----------------------------------------------------------------------------
// skt_intf: channel interfaces of the sorted key table
// Request, result and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_req_if;
	logic                      valid;
	logic                      ready;
	logic [skt_pkg::REQ_W-1:0] req_type;
	logic [skt_pkg::KEY_W-1:0] key;

	modport source (output valid, req_type, key, input ready);
	modport sink   (input valid, req_type, key, output ready);
endinterface

interface skt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [skt_pkg::KEY_W-1:0]  value;
	logic [skt_pkg::CNT_W-1:0]  count;
	logic [skt_pkg::STAT_W-1:0] status;
	logic                       last;

	modport source (output valid, value, count, status, last, input ready);
	modport sink   (input valid, value, count, status, last, output ready);
endinterface

interface skt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [skt_pkg::CFG_IDX_W-1:0] index;
	logic [skt_pkg::KEY_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skt_ctrl: request sequencer
// Decodes a request and steps the datapath through the entry walk.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      req_valid,
	output logic                     req_ready,
	input  wire [skt_pkg::REQ_W-1:0] req_type,
	input  skt_pkg::sts_t            sts,
	output skt_pkg::cmd_t            cmd
);

	skt_pkg::state_t  state_q, state_d;
	skt_pkg::req_t    req_q;
	skt_pkg::status_t stat_q, stat_d;
	logic             accept;

	assign req_ready = (state_q == skt_pkg::S_IDLE);
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
			req_q   <= skt_pkg::REQ_INSERT;
			stat_q  <= skt_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			if (accept)
				req_q <= skt_pkg::req_t'(req_type);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		stat_d  = stat_q;
		case (state_q)
			skt_pkg::S_IDLE: begin
				if (accept) begin
					stat_d = skt_pkg::ST_OK;
					case (req_type)
						skt_pkg::REQ_INSERT: begin
							if (sts.n_full) begin
								stat_d  = skt_pkg::ST_FULL;
								state_d = skt_pkg::S_RESP;
							end else if (sts.n_zero) begin
								state_d = skt_pkg::S_PLACE;
							end else begin
								state_d = skt_pkg::S_WALK;
							end
						end
						skt_pkg::REQ_COUNT, skt_pkg::REQ_REMOVE, skt_pkg::REQ_LIST: begin
							if (sts.n_zero) begin
								stat_d  = skt_pkg::ST_EMPTY;
								state_d = skt_pkg::S_RESP;
							end else begin
								state_d = skt_pkg::S_WALK;
							end
						end
						skt_pkg::REQ_MIN: begin
							if (sts.n_zero)
								stat_d = skt_pkg::ST_EMPTY;
							state_d = skt_pkg::S_RESP;
						end
						default: state_d = skt_pkg::S_IDLE;
					endcase
				end
			end
			skt_pkg::S_WALK: begin
				case (req_q)
					skt_pkg::REQ_INSERT: begin
						if (!sts.gt_key)
							state_d = skt_pkg::S_RESP;
						else if (sts.ptr_zero)
							state_d = skt_pkg::S_PLACE;
					end
					skt_pkg::REQ_COUNT, skt_pkg::REQ_REMOVE: begin
						if (sts.ptr_last)
							state_d = skt_pkg::S_RESP;
					end
					skt_pkg::REQ_LIST: begin
						if (!sts.lt_thr) begin
							if (sts.out_free && sts.ptr_last)
								state_d = skt_pkg::S_IDLE;
						end else if (sts.ptr_last) begin
							stat_d  = skt_pkg::ST_EMPTY;
							state_d = skt_pkg::S_RESP;
						end
					end
					default: state_d = skt_pkg::S_IDLE;
				endcase
			end
			skt_pkg::S_PLACE: state_d = skt_pkg::S_RESP;
			skt_pkg::S_RESP: begin
				if (sts.out_free)
					state_d = skt_pkg::S_IDLE;
			end
			default: state_d = skt_pkg::S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			skt_pkg::S_IDLE: begin
				if (accept) begin
					cmd.key_ld  = 1'b1;
					cmd.acc_clr = 1'b1;
					if (req_type == skt_pkg::REQ_INSERT)
						cmd.ptr_top = !sts.n_zero;
					else
						cmd.ptr_first = 1'b1;
				end
			end
			skt_pkg::S_WALK: begin
				case (req_q)
					skt_pkg::REQ_INSERT: begin
						cmd.mem_wr = 1'b1;
						if (sts.gt_key) begin
							cmd.wr_sel  = skt_pkg::WR_SHIFT;
							cmd.ptr_dec = !sts.ptr_zero;
						end else begin
							cmd.wr_sel = skt_pkg::WR_KEY_ABOVE;
							cmd.n_inc  = 1'b1;
						end
					end
					skt_pkg::REQ_COUNT: begin
						cmd.acc_inc = sts.lt_thr;
						cmd.ptr_inc = !sts.ptr_last;
					end
					skt_pkg::REQ_REMOVE: begin
						cmd.mem_wr    = !sts.eq_rmv;
						cmd.wr_sel    = skt_pkg::WR_COMPACT;
						cmd.wp_inc    = !sts.eq_rmv;
						cmd.acc_inc   = sts.eq_rmv;
						cmd.n_from_wp = sts.ptr_last;
						cmd.ptr_inc   = !sts.ptr_last;
					end
					skt_pkg::REQ_LIST: begin
						if (!sts.lt_thr) begin
							// hold on this entry until the output slot frees
							if (sts.out_free) begin
								cmd.emit    = 1'b1;
								cmd.val_sel = skt_pkg::VAL_DATA;
								cmd.cnt_sel = skt_pkg::CNT_ZERO;
								cmd.status  = skt_pkg::ST_OK;
								cmd.last    = sts.ptr_last;
								cmd.ptr_inc = !sts.ptr_last;
							end
						end else begin
							cmd.ptr_inc = !sts.ptr_last;
						end
					end
					default: cmd = '0;
				endcase
			end
			skt_pkg::S_PLACE: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = skt_pkg::WR_KEY_ZERO;
				cmd.n_inc  = 1'b1;
			end
			skt_pkg::S_RESP: begin
				cmd.emit   = sts.out_free;
				cmd.status = stat_q;
				cmd.last   = 1'b1;
				if (req_q == skt_pkg::REQ_MIN && stat_q == skt_pkg::ST_OK)
					cmd.val_sel = skt_pkg::VAL_DATA;
				else
					cmd.val_sel = skt_pkg::VAL_ZERO;
				if (stat_q == skt_pkg::ST_EMPTY)
					cmd.cnt_sel = skt_pkg::CNT_ZERO;
				else if (req_q == skt_pkg::REQ_INSERT)
					cmd.cnt_sel = skt_pkg::CNT_HELD;
				else if (req_q == skt_pkg::REQ_COUNT || req_q == skt_pkg::REQ_REMOVE)
					cmd.cnt_sel = skt_pkg::CNT_ACC;
				else
					cmd.cnt_sel = skt_pkg::CNT_ZERO;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/skt_dp.sv =====
// ----------------------------------------------------------------------------
// skt_dp: sorted key table datapath
// Entry memory, walk pointers, counters, config registers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_dp #(
	parameter int DEPTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [skt_pkg::KEY_W-1:0]     req_key,
	input  wire                          cfg_valid,
	input  wire [skt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [skt_pkg::KEY_W-1:0]     cfg_data,
	input  skt_pkg::cmd_t                cmd,
	output skt_pkg::sts_t                sts,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	output logic [skt_pkg::KEY_W-1:0]    rsp_value,
	output logic [skt_pkg::CNT_W-1:0]    rsp_count,
	output logic [skt_pkg::STAT_W-1:0]   rsp_status,
	output logic                         rsp_last
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int KW   = skt_pkg::KEY_W;
	localparam int CNTW = skt_pkg::CNT_W;

	logic [KW-1:0] mem_q [DEPTH];
	logic [KW-1:0] rdata_q;
	logic [AW-1:0] ptr_q, raddr, waddr;
	logic [KW-1:0] wdata;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] n_q, acc_q;
	logic [KW-1:0] key_q, thr_q, rmv_q;
	logic          out_free;

	// read address: the walk pointer follows it every cycle
	always_comb begin
		if (cmd.ptr_first)
			raddr = '0;
		else if (cmd.ptr_top)
			raddr = AW'(n_q - CW'(1));
		else if (cmd.ptr_inc)
			raddr = ptr_q + AW'(1);
		else if (cmd.ptr_dec)
			raddr = ptr_q - AW'(1);
		else
			raddr = ptr_q;
	end

	always_comb begin
		case (cmd.wr_sel)
			skt_pkg::WR_SHIFT: begin
				waddr = ptr_q + AW'(1);
				wdata = rdata_q;
			end
			skt_pkg::WR_KEY_ABOVE: begin
				waddr = ptr_q + AW'(1);
				wdata = key_q;
			end
			skt_pkg::WR_KEY_ZERO: begin
				waddr = '0;
				wdata = key_q;
			end
			skt_pkg::WR_COMPACT: begin
				waddr = wp_q;
				wdata = rdata_q;
			end
			default: begin
				waddr = '0;
				wdata = key_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		ptr_q <= raddr;
		if (cmd.key_ld)
			key_q <= req_key;
		if (cmd.acc_clr) begin
			acc_q <= '0;
			wp_q  <= '0;
		end else begin
			if (cmd.acc_inc)
				acc_q <= acc_q + CW'(1);
			if (cmd.wp_inc)
				wp_q <= wp_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			thr_q <= skt_pkg::THR_RESET;
			rmv_q <= skt_pkg::RMV_RESET;
		end else begin
			if (cmd.n_inc)
				n_q <= n_q + CW'(1);
			else if (cmd.n_from_wp)
				n_q <= CW'(wp_q) + CW'(cmd.mem_wr);
			if (cfg_valid) begin
				case (cfg_index)
					skt_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
					skt_pkg::CFG_REMOVE:    rmv_q <= cfg_data;
					default:                thr_q <= thr_q;
				endcase
			end
		end
	end

	// result register
	assign out_free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (cmd.emit)
			rsp_valid <= 1'b1;
		else if (rsp_ready)
			rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_value  <= (cmd.val_sel == skt_pkg::VAL_DATA) ? rdata_q : '0;
			case (cmd.cnt_sel)
				skt_pkg::CNT_HELD: rsp_count <= CNTW'(n_q);
				skt_pkg::CNT_ACC:  rsp_count <= CNTW'(acc_q);
				default:           rsp_count <= '0;
			endcase
			rsp_status <= cmd.status;
			rsp_last   <= cmd.last;
		end
	end

	assign sts.n_zero   = (n_q == '0);
	assign sts.n_full   = (n_q == CW'(DEPTH));
	assign sts.ptr_zero = (ptr_q == '0);
	assign sts.ptr_last = (CW'(ptr_q) == n_q - CW'(1));
	assign sts.gt_key   = (rdata_q > key_q);
	assign sts.lt_thr   = (rdata_q < thr_q);
	assign sts.eq_rmv   = (rdata_q == rmv_q);
	assign sts.out_free = out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table: ordered key table with insert, count, remove, min, list
// Holds up to DEPTH 10-bit keys in ascending order in a single-port-write,
// single-port-read memory and answers one request at a time.
// ----------------------------------------------------------------------------
// One request at a time. Insert walks down from the top key, moving each
// larger key up one slot; count and remove walk every key; list walks
// every key, emitting each key at or above the threshold, or an empty
// result when none is. An insert into a full table or a count, remove,
// list or read-minimum on an empty table goes straight to its result.
// Results and the list walk wait while the result side stalls. The entry
// memory delivers one registered read per cycle, so a walk visits one key
// per clock unless held. A finished result sits in an output register,
// so the next request is taken while it waits. Request types 5 to 7 are
// taken and dropped with no result. Configuration writes are always ready
// and must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table #(
	parameter int DEPTH = 16
) (
	input  wire       clk,
	input  wire       arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp,
	skt_cfg_if.sink   cfg
);

	skt_pkg::cmd_t cmd;
	skt_pkg::sts_t sts;

	// config port never pushes back
	assign cfg.ready = 1'b1;

	// controller: request decode and walk sequencing
	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_type  (req.req_type),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: entry memory, pointers, counters, result register
	skt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_key    (req.key),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.cmd        (cmd),
		.sts        (sts),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_value  (rsp.value),
		.rsp_count  (rsp.count),
		.rsp_status (rsp.status),
		.rsp_last   (rsp.last)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/skt_checker.sv =====
// ----------------------------------------------------------------------------
// skt_checker: result channel checks of the sorted key table
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_checker #(
	parameter int DEPTH = 16
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire [skt_pkg::KEY_W-1:0]     rsp_value,
	input wire [skt_pkg::CNT_W-1:0]     rsp_count,
	input wire [skt_pkg::STAT_W-1:0]    rsp_status,
	input wire                          rsp_last
);

	localparam int CNTW = skt_pkg::CNT_W;
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
			&& $stable(rsp_count) && $stable(rsp_status) && $stable(rsp_last))
		else $error("result changed while stalled");

	// full only reported with the table at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == skt_pkg::ST_FULL |->
			rsp_count == FULL_CNT && rsp_value == '0 && rsp_last)
		else $error("full status with wrong count");

	// empty result is a lone zero item
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == skt_pkg::ST_EMPTY |->
			rsp_value == '0 && rsp_count == '0 && rsp_last)
		else $error("empty status with data");

	// only list items come without last, and they are plain ok items
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == skt_pkg::ST_OK && rsp_count == '0)
		else $error("bad intermediate list item");

endmodule

bind sorted_key_table skt_checker #(
	.DEPTH (DEPTH)
) u_skt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.value),
	.rsp_count  (rsp.count),
	.rsp_status (rsp.status),
	.rsp_last   (rsp.last)
);

`default_nettype wire
